// ===== rtl/core/mlbt_pkg.sv =====
// ---------------------------------------------------------------------------
// Multi-lamp blink timer package
// Shared widths, command codes, register indexes and the lamp command type.
// ---------------------------------------------------------------------------
package mlbt_pkg;

    // Field widths.
    localparam int CNT_W    = 15;
    localparam int ACTION_W = 3;
    localparam int INDEX_W  = 2;
    localparam int LEVELS_W = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = CNT_W;

    // Default lamp count.
    localparam int NUM_LAMPS_DEF = 4;

    // Command codes.
    localparam logic [ACTION_W-1:0] ACT_TICK         = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_LAMP_ON      = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_LAMP_OFF     = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_BLINK_DEF    = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_BLINK_CUSTOM = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_PERIOD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_ON_TIME = 2'd1;

    // Reset values.
    localparam logic [CNT_W-1:0] DEFAULT_PERIOD_RST  = 15'd1000;
    localparam logic [CNT_W-1:0] DEFAULT_ON_TIME_RST = 15'd100;

    // Decoded command as seen by every lamp.
    typedef struct packed {
        logic             tick;
        logic             set_on;
        logic             set_off;
        logic             start;
        logic [CNT_W-1:0] period;
        logic [CNT_W-1:0] on_time;
    } lamp_cmd_t;

endpackage

// ===== rtl/core/mlbt_lamp.sv =====
// ---------------------------------------------------------------------------
// Multi-lamp blink timer: one lamp
// Holds the blink state and counters of one lamp and works out its next
// state for the command in flight. The state is written when adv is high.
// ---------------------------------------------------------------------------
module mlbt_lamp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mlbt_pkg::lamp_cmd_t  cmd,
    input  logic                 sel,
    input  logic                 adv,
    output logic                 lit_next
);

    logic                       blinking_reg, blinking_next;
    logic                       lit_reg;
    logic [mlbt_pkg::CNT_W-1:0] period_reg, period_next;
    logic [mlbt_pkg::CNT_W-1:0] on_time_reg, on_time_next;
    logic [mlbt_pkg::CNT_W-1:0] pcount_reg, pcount_next;
    logic [mlbt_pkg::CNT_W-1:0] ocount_reg, ocount_next;
    logic [mlbt_pkg::CNT_W:0]   pcount_inc;
    logic [mlbt_pkg::CNT_W-1:0] ocount_inc;

    // Next-state logic for one tick or one addressed command.
    always_comb begin
        blinking_next = blinking_reg;
        lit_next      = lit_reg;
        period_next   = period_reg;
        on_time_next  = on_time_reg;
        pcount_next   = pcount_reg;
        ocount_next   = ocount_reg;
        pcount_inc    = {1'b0, pcount_reg} + {{mlbt_pkg::CNT_W{1'b0}}, 1'b1};
        ocount_inc    = ocount_reg + {{(mlbt_pkg::CNT_W-1){1'b0}}, 1'b1};

        priority if (cmd.tick) begin
            if (blinking_reg) begin
                if (pcount_inc >= {1'b0, period_reg}) begin
                    // Period end: a dark lamp relights, a lit one holds.
                    if (!lit_reg) begin
                        lit_next    = 1'b1;
                        ocount_next = '0;
                        pcount_next = '0;
                    end else begin
                        pcount_next = period_reg;
                    end
                end else begin
                    pcount_next = pcount_inc[mlbt_pkg::CNT_W-1:0];
                    if (lit_reg) begin
                        ocount_next = ocount_inc;
                        if (ocount_inc >= on_time_reg) begin
                            lit_next = 1'b0;
                        end
                    end
                end
            end
        end else if (sel && cmd.set_on) begin
            blinking_next = 1'b0;
            lit_next      = 1'b1;
        end else if (sel && cmd.set_off) begin
            blinking_next = 1'b0;
            lit_next      = 1'b0;
        end else if (sel && cmd.start) begin
            period_next   = cmd.period;
            on_time_next  = cmd.on_time;
            pcount_next   = '0;
            ocount_next   = '0;
            blinking_next = 1'b1;
            lit_next      = 1'b1;
        end else begin
            // Commands for other lamps and spare codes keep this lamp as it is.
        end
    end

    // Lamp state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blinking_reg <= 1'b0;
            lit_reg      <= 1'b0;
            period_reg   <= mlbt_pkg::DEFAULT_PERIOD_RST;
            on_time_reg  <= mlbt_pkg::DEFAULT_ON_TIME_RST;
            pcount_reg   <= '0;
            ocount_reg   <= '0;
        end else if (adv) begin
            blinking_reg <= blinking_next;
            lit_reg      <= lit_next;
            period_reg   <= period_next;
            on_time_reg  <= on_time_next;
            pcount_reg   <= pcount_next;
            ocount_reg   <= ocount_next;
        end
    end

endmodule

// ===== rtl/core/multi_led_blink_timer_core.sv =====
// ---------------------------------------------------------------------------
// Multi-lamp blink timer core
// Takes one command per beat, updates every lamp and returns the lamp levels.
// ---------------------------------------------------------------------------
// The block accepts one command beat per clock while the output is not
// stalled by m_ready, and returns one result beat per command, in order. A
// beat is captured in an input register; once the output register is free,
// all lamps update and the new levels land in the output register at the
// same edge. The sustained rate is one beat per cycle while m_ready stays
// high. Configuration writes take effect at once and are meant to be
// issued while no command is in flight.
module multi_led_blink_timer_core #(
    parameter int NUM_LAMPS = mlbt_pkg::NUM_LAMPS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [mlbt_pkg::ACTION_W-1:0]     s_action,
    input  logic [mlbt_pkg::INDEX_W-1:0]      s_led_index,
    input  logic [mlbt_pkg::CNT_W-1:0]        s_period,
    input  logic [mlbt_pkg::CNT_W-1:0]        s_on_time,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [mlbt_pkg::LEVELS_W-1:0]     m_lamp_levels,
    input  logic                              cfg_we,
    input  logic [mlbt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mlbt_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    logic                             s1_valid_reg;
    logic [mlbt_pkg::ACTION_W-1:0]    s1_action_reg;
    logic [mlbt_pkg::INDEX_W-1:0]     s1_led_index_reg;
    logic [mlbt_pkg::CNT_W-1:0]       s1_period_reg;
    logic [mlbt_pkg::CNT_W-1:0]       s1_on_time_reg;
    logic                             m_valid_reg;
    logic [mlbt_pkg::LEVELS_W-1:0]    m_lamp_levels_reg, m_lamp_levels_next;
    logic [mlbt_pkg::CNT_W-1:0]       default_period_reg;
    logic [mlbt_pkg::CNT_W-1:0]       default_on_time_reg;
    logic                             adv;
    mlbt_pkg::lamp_cmd_t              cmd;
    logic [NUM_LAMPS-1:0]             lamp_sel;
    logic [NUM_LAMPS-1:0]             lamp_lit_next;

    // Handshake: the input stage drains whenever the output register frees up.
    assign adv     = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || adv;
    assign m_valid       = m_valid_reg;
    assign m_lamp_levels = m_lamp_levels_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            default_period_reg  <= mlbt_pkg::DEFAULT_PERIOD_RST;
            default_on_time_reg <= mlbt_pkg::DEFAULT_ON_TIME_RST;
        end else if (cfg_we) begin
            if (cfg_index == mlbt_pkg::CFG_DEFAULT_PERIOD) begin
                default_period_reg <= cfg_wdata;
            end
            if (cfg_index == mlbt_pkg::CFG_DEFAULT_ON_TIME) begin
                default_on_time_reg <= cfg_wdata;
            end
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            s1_action_reg    <= s_action;
            s1_led_index_reg <= s_led_index;
            s1_period_reg    <= s_period;
            s1_on_time_reg   <= s_on_time;
        end
    end

    // Decode the registered command for the lamps.
    always_comb begin
        cmd         = '0;
        cmd.period  = s1_period_reg;
        cmd.on_time = s1_on_time_reg;
        unique case (s1_action_reg)
            mlbt_pkg::ACT_TICK:      cmd.tick    = 1'b1;
            mlbt_pkg::ACT_LAMP_ON:   cmd.set_on  = 1'b1;
            mlbt_pkg::ACT_LAMP_OFF:  cmd.set_off = 1'b1;
            mlbt_pkg::ACT_BLINK_DEF: begin
                cmd.start   = 1'b1;
                cmd.period  = default_period_reg;
                cmd.on_time = default_on_time_reg;
            end
            mlbt_pkg::ACT_BLINK_CUSTOM: cmd.start = 1'b1;
            default: ;
        endcase
    end

    // One lamp per channel.
    for (genvar n = 0; n < NUM_LAMPS; n++) begin : g_lamp
        assign lamp_sel[n] = (32'(s1_led_index_reg) == n);

        mlbt_lamp u_lamp (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cmd      (cmd),
            .sel      (lamp_sel[n]),
            .adv      (adv),
            .lit_next (lamp_lit_next[n])
        );
    end

    // Result levels: lamps beyond the output width are not reported.
    for (genvar b = 0; b < mlbt_pkg::LEVELS_W; b++) begin : g_level
        if (b < NUM_LAMPS) begin : g_used
            assign m_lamp_levels_next[b] = lamp_lit_next[b];
        end else begin : g_unused
            assign m_lamp_levels_next[b] = 1'b0;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_lamp_levels_reg <= m_lamp_levels_next;
        end
    end

    // The input side only stalls while the input register holds a beat.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> s1_valid_reg)
        else $error("input stalled with an empty input register");

    // An accepted beat is held in the input register on the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> s1_valid_reg)
        else $error("accepted beat was lost");

    // An off command leaves the addressed lamp dark in its result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && s1_action_reg == mlbt_pkg::ACT_LAMP_OFF)
        |=> !m_lamp_levels_reg[$past(s1_led_index_reg)])
        else $error("lamp still lit after an off command");

endmodule
